[src/ddmp_pkg.sv]
package ddmp_pkg;

	typedef enum logic [1:0] {
		CMD_MOVE  = 2'd0,
		CMD_SERVO = 2'd1,
		CMD_HOME  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_HALF_TRACK = 2'd0;
	localparam logic [1:0] REG_RATE       = 2'd1;
	localparam logic [1:0] REG_MAX_SPEED  = 2'd2;
	localparam logic [1:0] REG_DEG_SCALE  = 2'd3;

	localparam logic signed [32:0] KINV_Q30   = 33'sd652032874;
	localparam logic signed [32:0] TWO_PI_Q20 = 33'sd6588397;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_HOME,
		OP_CORDIC,
		OP_PRIME,
		OP_DELTA,
		OP_DIST,
		OP_TMUL1,
		OP_TMUL2,
		OP_TMUL3,
		OP_SEG_TURN,
		OP_SEG_FWD,
		OP_VL,
		OP_VR,
		OP_CHECK,
		OP_CHUNK,
		OP_DEGL,
		OP_DEGR,
		OP_EMIT_WHEEL,
		OP_EMIT_SERVO
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic nz;
		logic turn;
		logic cordic_last;
		logic seg_last;
		logic seg_fwd;
		logic out_free;
	} dp_stat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_PRIME,
		ST_DELTA,
		ST_DIST,
		ST_TMUL1,
		ST_TMUL2,
		ST_TMUL3,
		ST_PLAN,
		ST_FWD,
		ST_VL,
		ST_VR,
		ST_CHECK,
		ST_CHUNK,
		ST_DEGL,
		ST_DEGR,
		ST_EMIT,
		ST_SERVO
	} state_t;

	// arctangent of 2^-i in units of 2*pi / 2^32
	function automatic logic [31:0] atan_at(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage

[src/ddmp_ctrl.sv]
module ddmp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	output logic               in_ready,
	input  ddmp_pkg::dp_stat_t stat,
	output ddmp_pkg::dp_cmd_t  cmd
);

	ddmp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = ddmp_pkg::OP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ddmp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_cmd)
						ddmp_pkg::CMD_MOVE: begin
							cmd.op  = ddmp_pkg::OP_LOAD;
							state_d = ddmp_pkg::ST_CORDIC;
						end
						ddmp_pkg::CMD_SERVO: begin
							cmd.op  = ddmp_pkg::OP_LOAD;
							state_d = ddmp_pkg::ST_SERVO;
						end
						ddmp_pkg::CMD_HOME: cmd.op = ddmp_pkg::OP_HOME;
						default: ;
					endcase
				end
			end
			ddmp_pkg::ST_CORDIC: begin
				// zero displacement skips the rotation
				if (!stat.nz) begin
					state_d = ddmp_pkg::ST_PRIME;
				end else begin
					cmd.op = ddmp_pkg::OP_CORDIC;
					if (stat.cordic_last) state_d = ddmp_pkg::ST_PRIME;
				end
			end
			ddmp_pkg::ST_PRIME: begin
				cmd.op  = ddmp_pkg::OP_PRIME;
				state_d = ddmp_pkg::ST_DELTA;
			end
			ddmp_pkg::ST_DELTA: begin
				cmd.op  = ddmp_pkg::OP_DELTA;
				state_d = ddmp_pkg::ST_DIST;
			end
			ddmp_pkg::ST_DIST: begin
				cmd.op  = ddmp_pkg::OP_DIST;
				state_d = ddmp_pkg::ST_TMUL1;
			end
			ddmp_pkg::ST_TMUL1: begin
				cmd.op  = ddmp_pkg::OP_TMUL1;
				state_d = ddmp_pkg::ST_TMUL2;
			end
			ddmp_pkg::ST_TMUL2: begin
				cmd.op  = ddmp_pkg::OP_TMUL2;
				state_d = ddmp_pkg::ST_TMUL3;
			end
			ddmp_pkg::ST_TMUL3: begin
				cmd.op  = ddmp_pkg::OP_TMUL3;
				state_d = ddmp_pkg::ST_PLAN;
			end
			ddmp_pkg::ST_PLAN: begin
				priority if (stat.turn) begin
					cmd.op  = ddmp_pkg::OP_SEG_TURN;
					state_d = ddmp_pkg::ST_VL;
				end else if (stat.nz) begin
					cmd.op  = ddmp_pkg::OP_SEG_FWD;
					state_d = ddmp_pkg::ST_VL;
				end else begin
					state_d = ddmp_pkg::ST_IDLE;
				end
			end
			ddmp_pkg::ST_FWD: begin
				cmd.op  = ddmp_pkg::OP_SEG_FWD;
				state_d = ddmp_pkg::ST_VL;
			end
			ddmp_pkg::ST_VL: begin
				cmd.op  = ddmp_pkg::OP_VL;
				state_d = ddmp_pkg::ST_VR;
			end
			ddmp_pkg::ST_VR: begin
				cmd.op  = ddmp_pkg::OP_VR;
				state_d = ddmp_pkg::ST_CHECK;
			end
			ddmp_pkg::ST_CHECK: begin
				cmd.op  = ddmp_pkg::OP_CHECK;
				state_d = ddmp_pkg::ST_CHUNK;
			end
			ddmp_pkg::ST_CHUNK: begin
				cmd.op  = ddmp_pkg::OP_CHUNK;
				state_d = ddmp_pkg::ST_DEGL;
			end
			ddmp_pkg::ST_DEGL: begin
				cmd.op  = ddmp_pkg::OP_DEGL;
				state_d = ddmp_pkg::ST_DEGR;
			end
			ddmp_pkg::ST_DEGR: begin
				cmd.op  = ddmp_pkg::OP_DEGR;
				state_d = ddmp_pkg::ST_EMIT;
			end
			ddmp_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					cmd.op = ddmp_pkg::OP_EMIT_WHEEL;
					priority if (!stat.seg_last) begin
						state_d = ddmp_pkg::ST_CHUNK;
					end else if (!stat.seg_fwd && stat.nz) begin
						state_d = ddmp_pkg::ST_FWD;
					end else begin
						state_d = ddmp_pkg::ST_IDLE;
					end
				end
			end
			ddmp_pkg::ST_SERVO: begin
				if (stat.out_free) begin
					cmd.op  = ddmp_pkg::OP_EMIT_SERVO;
					state_d = ddmp_pkg::ST_IDLE;
				end
			end
			default: state_d = ddmp_pkg::ST_IDLE;
		endcase
	end

endmodule

[src/ddmp_dp.sv]
module ddmp_dp #(
	parameter int MAX_CHUNKS   = 32,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddmp_pkg::dp_cmd_t   cmd,
	output ddmp_pkg::dp_stat_t  stat,
	input  logic signed [15:0]  dx,
	input  logic signed [15:0]  dy,
	input  logic                servo_pick,
	input  logic [7:0]          servo_angle_in,
	input  logic [7:0]          packet_tag,
	input  logic [15:0]         half_track_q8,
	input  logic [9:0]          control_rate_hz,
	input  logic [15:0]         max_wheel_speed,
	input  logic [23:0]         wheel_deg_scale_q16,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                kind,
	output logic signed [15:0]  left_speed,
	output logic signed [15:0]  right_speed,
	output logic                servo_pick_out,
	output logic [7:0]          servo_angle_out,
	output logic [7:0]          packet_out,
	output logic                last_of_run,
	output logic                truncated
);

	localparam int AB = ANGLE_BITS;
	localparam int S  = 32 - ANGLE_BITS;
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam longint THR_L = ((longint'(1) << ANGLE_BITS) * 64'd15915494) / 64'd10000000000;
	localparam logic [AB+1:0] THR = (AB+2)'(THR_L);
	localparam logic signed [AB:0] HALF = {2'b01, {(AB-1){1'b0}}};
	localparam logic signed [AB+1:0] HALF2 = {3'b001, {(AB-1){1'b0}}};
	localparam logic signed [AB+1:0] FULL = {2'b01, {AB{1'b0}}};
	localparam logic [AB-1:0] PI_CODE = {1'b1, {(AB-1){1'b0}}};

	typedef struct packed {
		logic signed [36:0] rest;
		logic [23:0]        mag;
		logic               neg;
	} chunk_t;

	// control state
	logic [AB-1:0] heading_q;
	logic          out_valid_q;

	// payload
	logic signed [32:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [IW-1:0]      i_q;
	logic               nz_q, pick_q;
	logic [7:0]         ang_in_q, tag_q;
	logic signed [AB:0] prime_q;
	logic signed [AB+1:0] delta_q;
	logic signed [25:0] dist_q, dl_q, dr_q;
	logic signed [43:0] p1_q;
	logic signed [65:0] acc_q;
	logic signed [36:0] vl_q, vr_q;
	logic               trunc_q, seg_last_q, seg_fwd_q;
	logic [CW-1:0]      cnt_q;
	logic [23:0]        clm_q, crm_q;
	logic               cln_q, crn_q;
	logic signed [15:0] degl_q, degr_q;
	logic               o_kind_q, o_pick_q, o_last_q, o_trunc_q;
	logic signed [15:0] o_l_q, o_r_q;
	logic [7:0]         o_ang_q, o_tag_q;

	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;

	logic signed [32:0] xi, yi;
	logic signed [32:0] xs, ys;
	logic signed [33:0] at, zr, af;
	logic [AB-1:0]      code;
	logic signed [AB:0] hn;
	logic signed [AB+1:0] d0, dw, dabs;
	logic signed [25:0] t;
	logic [23:0]        lim;
	logic signed [36:0] limv, limmax, al, ar, m;
	chunk_t             tl, tr;
	logic               out_free, emit;

	function automatic chunk_t take(input logic signed [36:0] v, input logic signed [36:0] lv);
		chunk_t c;
		logic signed [36:0] av;
		av = (v < 0) ? -v : v;
		priority if (v > lv) begin
			c.rest = v - lv;
			c.mag  = lv[23:0];
			c.neg  = 1'b0;
		end else if (v < -lv) begin
			c.rest = v + lv;
			c.mag  = lv[23:0];
			c.neg  = 1'b1;
		end else begin
			c.rest = '0;
			c.mag  = av[23:0];
			c.neg  = v < 0;
		end
		return c;
	endfunction

	function automatic logic signed [15:0] sat(input logic [24:0] mag, input logic neg);
		logic signed [15:0] r;
		if (neg) begin
			r = (mag > 25'd32768) ? 16'sh8000 : -$signed(mag[15:0]);
		end else begin
			r = (mag > 25'd32767) ? 16'sh7fff : $signed(mag[15:0]);
		end
		return r;
	endfunction

	// shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			ddmp_pkg::OP_DIST: begin
				ma = x_q;
				mb = ddmp_pkg::KINV_Q30;
			end
			ddmp_pkg::OP_TMUL1: begin
				ma = 33'(delta_q);
				mb = $signed({17'b0, half_track_q8});
			end
			ddmp_pkg::OP_TMUL2: begin
				ma = $signed({12'b0, p1_q[20:0]});
				mb = ddmp_pkg::TWO_PI_Q20;
			end
			ddmp_pkg::OP_TMUL3: begin
				ma = 33'($signed(p1_q[43:21]));
				mb = ddmp_pkg::TWO_PI_Q20;
			end
			ddmp_pkg::OP_VL: begin
				ma = 33'(dl_q);
				mb = $signed({23'b0, control_rate_hz});
			end
			ddmp_pkg::OP_VR: begin
				ma = 33'(dr_q);
				mb = $signed({23'b0, control_rate_hz});
			end
			ddmp_pkg::OP_DEGL: begin
				ma = $signed({9'b0, clm_q});
				mb = $signed({9'b0, wheel_deg_scale_q16});
			end
			ddmp_pkg::OP_DEGR: begin
				ma = $signed({9'b0, crm_q});
				mb = $signed({9'b0, wheel_deg_scale_q16});
			end
			default: ;
		endcase
	end

	assign mp = ma * mb;

	always_comb begin
		xi   = $signed({{3{dx[15]}}, dx, 14'b0});
		yi   = $signed({{3{dy[15]}}, dy, 14'b0});
		xs   = x_q >>> i_q;
		ys   = y_q >>> i_q;
		at   = $signed({2'b00, ddmp_pkg::atan_at(5'(i_q))});
		zr   = z_q + (34'sd1 <<< (S - 1));
		af   = zr >>> S;
		code = af[AB-1:0];
		hn   = (heading_q == PI_CODE) ? HALF : $signed({heading_q[AB-1], heading_q});
		d0   = (AB+2)'(prime_q) - (AB+2)'(hn);
		priority if (d0 > HALF2) dw = d0 - FULL;
		else if (d0 < -HALF2) dw = d0 + FULL;
		else dw = d0;
		dabs   = (delta_q < 0) ? -delta_q : delta_q;
		t      = 26'(acc_q >>> (AB + 20));
		lim    = {((max_wheel_speed == 16'd0) ? 16'd1 : max_wheel_speed), 8'b0};
		limv   = $signed({13'b0, lim});
		limmax = limv * 37'(MAX_CHUNKS);
		al     = (vl_q < 0) ? -vl_q : vl_q;
		ar     = (vr_q < 0) ? -vr_q : vr_q;
		m      = (al > ar) ? al : ar;
		tl     = take(vl_q, limv);
		tr     = take(vr_q, limv);
	end

	assign out_free = !out_valid_q || out_ready;
	assign emit = (cmd.op == ddmp_pkg::OP_EMIT_WHEEL) || (cmd.op == ddmp_pkg::OP_EMIT_SERVO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == ddmp_pkg::OP_HOME) heading_q <= '0;
			else if (cmd.op == ddmp_pkg::OP_DELTA) heading_q <= prime_q[AB-1:0];
			if (emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ddmp_pkg::OP_LOAD: begin
				nz_q     <= (dx != 16'sd0) || (dy != 16'sd0);
				pick_q   <= servo_pick;
				ang_in_q <= servo_angle_in;
				tag_q    <= packet_tag;
				i_q      <= '0;
				// pre-rotate the left half plane by pi
				if (dx < 0) begin
					x_q <= -xi;
					y_q <= -yi;
					z_q <= (dy >= 0) ? 34'sh080000000 : -34'sh080000000;
				end else begin
					x_q <= xi;
					y_q <= yi;
					z_q <= '0;
				end
			end
			ddmp_pkg::OP_CORDIC: begin
				i_q <= i_q + 1'b1;
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end
			end
			ddmp_pkg::OP_PRIME: begin
				if (!nz_q) prime_q <= '0;
				else if (code == PI_CODE) prime_q <= HALF;
				else prime_q <= $signed({code[AB-1], code});
			end
			ddmp_pkg::OP_DELTA: delta_q <= dw;
			ddmp_pkg::OP_DIST:  dist_q <= mp[61:36];
			ddmp_pkg::OP_TMUL1: p1_q <= mp[43:0];
			ddmp_pkg::OP_TMUL2: acc_q <= mp;
			ddmp_pkg::OP_TMUL3: acc_q <= acc_q + (mp <<< 21);
			ddmp_pkg::OP_SEG_TURN: begin
				dl_q      <= -t;
				dr_q      <= t;
				seg_fwd_q <= 1'b0;
			end
			ddmp_pkg::OP_SEG_FWD: begin
				dl_q      <= dist_q;
				dr_q      <= dist_q;
				seg_fwd_q <= 1'b1;
			end
			ddmp_pkg::OP_VL: vl_q <= mp[36:0];
			ddmp_pkg::OP_VR: vr_q <= mp[36:0];
			ddmp_pkg::OP_CHECK: begin
				trunc_q <= m > limmax;
				cnt_q   <= '0;
			end
			ddmp_pkg::OP_CHUNK: begin
				vl_q       <= tl.rest;
				vr_q       <= tr.rest;
				clm_q      <= tl.mag;
				cln_q      <= tl.neg;
				crm_q      <= tr.mag;
				crn_q      <= tr.neg;
				cnt_q      <= cnt_q + 1'b1;
				seg_last_q <= ((tl.rest == 0) && (tr.rest == 0))
					|| (cnt_q == CW'(MAX_CHUNKS - 1));
			end
			ddmp_pkg::OP_DEGL: degl_q <= sat(mp[48:24], cln_q);
			ddmp_pkg::OP_DEGR: degr_q <= sat(mp[48:24], crn_q);
			ddmp_pkg::OP_EMIT_WHEEL: begin
				o_kind_q  <= 1'b0;
				o_l_q     <= degl_q;
				o_r_q     <= degr_q;
				o_pick_q  <= 1'b0;
				o_ang_q   <= '0;
				o_tag_q   <= tag_q;
				o_last_q  <= seg_last_q && (seg_fwd_q || !nz_q);
				o_trunc_q <= trunc_q;
			end
			ddmp_pkg::OP_EMIT_SERVO: begin
				o_kind_q  <= 1'b1;
				o_l_q     <= '0;
				o_r_q     <= '0;
				o_pick_q  <= pick_q;
				o_ang_q   <= ang_in_q;
				o_tag_q   <= tag_q;
				o_last_q  <= 1'b1;
				o_trunc_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign stat.nz          = nz_q;
	assign stat.turn        = dabs > $signed(THR);
	assign stat.cordic_last = i_q == IW'(CORDIC_STEPS - 1);
	assign stat.seg_last    = seg_last_q;
	assign stat.seg_fwd     = seg_fwd_q;
	assign stat.out_free    = out_free;

	assign out_valid       = out_valid_q;
	assign kind            = o_kind_q;
	assign left_speed      = o_l_q;
	assign right_speed     = o_r_q;
	assign servo_pick_out  = o_pick_q;
	assign servo_angle_out = o_ang_q;
	assign packet_out      = o_tag_q;
	assign last_of_run     = o_last_q;
	assign truncated       = o_trunc_q;

endmodule

[src/diff_drive_motion_planner_unit.sv]
// Differential-drive planner: each move request (tuser 0) is turned into a CORDIC heading and
// distance, then into a turn segment if the heading change passes the threshold and a forward
// segment if the displacement is nonzero, each sliced into up to MAX_CHUNKS wheel-speed chunks
// sent on the output stream in deg/s; a servo request (tuser 1) produces one servo result and
// a home request (tuser 2) clears the stored heading. One request is in work at a time, and
// one shared multiplier serves distance, turn, speed and deg/s scaling. Output stalls hold
// the planner until the output register is free.
module diff_drive_motion_planner_unit #(
	parameter int MAX_CHUNKS   = 32,
	parameter int ANGLE_BITS   = 16,
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// dx[15:0], dy[31:16], servo_pick[32], servo_angle_in[40:33], packet_tag[48:41]
	input  logic [55:0] s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// left_speed[15:0], right_speed[31:16], servo_pick_out[32],
	// servo_angle_out[40:33], packet_out[48:41], truncated[49]
	output logic [55:0] m_axis_tdata,
	// kind[0]
	output logic        m_axis_tuser,
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] half_track_q;
	logic [9:0]  rate_q;
	logic [15:0] max_speed_q;
	logic [23:0] deg_scale_q;

	ddmp_pkg::dp_cmd_t  cmd;
	ddmp_pkg::dp_stat_t stat;

	logic               kind, pick_o, last_o, trunc_o;
	logic signed [15:0] left_v, right_v;
	logic [7:0]         ang_o, tag_o;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_track_q <= 16'd12800;
			rate_q       <= 10'd10;
			max_speed_q  <= 16'd100;
			deg_scale_q  <= 24'd187745;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				ddmp_pkg::REG_HALF_TRACK: half_track_q <= pwdata[15:0];
				ddmp_pkg::REG_RATE:       rate_q       <= pwdata[9:0];
				ddmp_pkg::REG_MAX_SPEED:  max_speed_q  <= pwdata[15:0];
				ddmp_pkg::REG_DEG_SCALE:  deg_scale_q  <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ddmp_pkg::REG_HALF_TRACK: prdata = {16'b0, half_track_q};
			ddmp_pkg::REG_RATE:       prdata = {22'b0, rate_q};
			ddmp_pkg::REG_MAX_SPEED:  prdata = {16'b0, max_speed_q};
			ddmp_pkg::REG_DEG_SCALE:  prdata = {8'b0, deg_scale_q};
			default:                  prdata = '0;
		endcase
	end

	ddmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_cmd   (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ddmp_dp #(
		.MAX_CHUNKS   (MAX_CHUNKS),
		.ANGLE_BITS   (ANGLE_BITS),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.dx                  ($signed(s_axis_tdata[15:0])),
		.dy                  ($signed(s_axis_tdata[31:16])),
		.servo_pick          (s_axis_tdata[32]),
		.servo_angle_in      (s_axis_tdata[40:33]),
		.packet_tag          (s_axis_tdata[48:41]),
		.half_track_q8       (half_track_q),
		.control_rate_hz     (rate_q),
		.max_wheel_speed     (max_speed_q),
		.wheel_deg_scale_q16 (deg_scale_q),
		.out_ready           (m_axis_tready),
		.out_valid           (m_axis_tvalid),
		.kind                (kind),
		.left_speed          (left_v),
		.right_speed         (right_v),
		.servo_pick_out      (pick_o),
		.servo_angle_out     (ang_o),
		.packet_out          (tag_o),
		.last_of_run         (last_o),
		.truncated           (trunc_o)
	);

	assign m_axis_tdata = {6'b0, trunc_o, tag_o, ang_o, pick_o, right_v, left_v};
	assign m_axis_tuser = kind;
	assign m_axis_tlast = last_o;

`ifndef NO_ASSERTIONS
	a_move_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == ddmp_pkg::CMD_MOVE)
		|=> !s_axis_tready)
		else $error("move request did not leave idle");

	a_servo_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
		else $error("servo result without last flag");

	a_servo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[49]))
		else $error("servo result carries wheel data");
`endif

endmodule

[tb/tb_diff_drive_motion_planner_unit.sv]
`timescale 1ns / 100ps

module tb_diff_drive_motion_planner_unit;

	localparam int MAX_CHUNKS_TB = 32;

	typedef struct {
		ddmp_pkg::cmd_t     cmd;
		logic signed [15:0] dx;
		logic signed [15:0] dy;
		logic               pick;
		logic [7:0]         angle;
		logic [7:0]         tag;
	} request_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] left_v;
		logic signed [15:0] right_v;
		logic               pick;
		logic [7:0]         angle;
		logic [7:0]         tag;
		logic               last;
		logic               trunc;
	} wheel_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	diff_drive_motion_planner_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	request_t   pending_reqs[$];
	wheel_cmd_t expected_cmds[$];
	request_t   cur_req;
	int         idle_pct;
	int         stall_pct;
	int         errors;
	int         n_reqs;
	int         n_results;
	int         n_truncated;

	// planner mirror
	logic [15:0] heading;
	longint      half_track;
	longint      rate_hz;
	longint      speed_lim;
	longint      deg_scale;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic longint norm_angle(input logic [15:0] code);
		longint v;
		v = longint'($signed(code));
		if (v == -32768)
			v = 32768;
		return v;
	endfunction

	function automatic longint deg_per_s(input longint v);
		longint mag;
		mag = v < 0 ? -v : v;
		mag = (mag * deg_scale) >>> 24;
		if (v < 0)
			return mag > 32768 ? -32768 : -mag;
		return mag > 32767 ? 32767 : mag;
	endfunction

	function automatic longint next_chunk(inout longint v, input longint lim);
		longint c;
		if (v > lim) begin
			v -= lim;
			return lim;
		end
		if (v < -lim) begin
			v += lim;
			return -lim;
		end
		c = v;
		v = 0;
		return c;
	endfunction

	function automatic logic [31:0] atan_ref(input int i);
		logic [31:0] tab[16];
		tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D};
		return tab[i];
	endfunction

	task automatic plan_segment(input longint dl, input longint dr, input logic [7:0] tag,
			inout wheel_cmd_t run[$]);
		longint vl, vr, lim, m, need, k, cl, cr;
		wheel_cmd_t w;
		vl = dl * rate_hz;
		vr = dr * rate_hz;
		lim = (speed_lim != 0 ? speed_lim : 1) * 256;
		m = vl < 0 ? -vl : vl;
		if ((vr < 0 ? -vr : vr) > m)
			m = vr < 0 ? -vr : vr;
		need = m == 0 ? 1 : (m + lim - 1) / lim;
		w = '{default: '0};
		w.tag = tag;
		w.trunc = need > MAX_CHUNKS_TB;
		if (w.trunc) begin
			need = MAX_CHUNKS_TB;
			n_truncated++;
		end
		for (k = 0; k < need; k++) begin
			cl = next_chunk(vl, lim);
			cr = next_chunk(vr, lim);
			w.left_v = 16'(deg_per_s(cl));
			w.right_v = 16'(deg_per_s(cr));
			run.push_back(w);
		end
	endtask

	task automatic predict_request(input request_t r);
		wheel_cmd_t run[$];
		wheel_cmd_t w;
		longint x, y, z, xs, ys, prime, fwd_len, delta, t;
		run = {};
		case (r.cmd)
			ddmp_pkg::CMD_SERVO: begin
				w = '{default: '0};
				w.kind = 1'b1;
				w.pick = r.pick;
				w.angle = r.angle;
				w.tag = r.tag;
				run.push_back(w);
			end
			ddmp_pkg::CMD_HOME: heading = '0;
			ddmp_pkg::CMD_MOVE: begin
				prime = 0;
				fwd_len = 0;
				if (r.dx != 0 || r.dy != 0) begin
					// vectoring CORDIC, left half-plane folded first
					x = longint'(r.dx) * 16384;
					y = longint'(r.dy) * 16384;
					z = 0;
					if (x < 0) begin
						z = y >= 0 ? (longint'(1) << 31) : -(longint'(1) << 31);
						x = -x;
						y = -y;
					end
					for (int i = 0; i < 16; i++) begin
						xs = x >>> i;
						ys = y >>> i;
						if (y > 0) begin
							x += ys;
							y -= xs;
							z += longint'(atan_ref(i));
						end else begin
							x -= ys;
							y += xs;
							z -= longint'(atan_ref(i));
						end
					end
					prime = norm_angle(16'((z + 32768) >>> 16));
					fwd_len = (x * 652032874) >>> 36;
				end
				delta = prime - norm_angle(heading);
				if (delta > 32768)
					delta -= 65536;
				if (delta < -32768)
					delta += 65536;
				heading = 16'(prime);
				if ((delta < 0 ? -delta : delta) > 104) begin
					t = (delta * half_track * 6588397) >>> 36;
					plan_segment(-t, t, r.tag, run);
				end
				if (r.dx != 0 || r.dy != 0)
					plan_segment(fwd_len, fwd_len, r.tag, run);
			end
			default: ;
		endcase
		if (run.size() > 0)
			run[run.size() - 1].last = 1'b1;
		foreach (run[i])
			expected_cmds.push_back(run[i]);
	endtask

	// request driver
	always @(posedge clk) begin : drive_requests
		request_t nxt;
		if (s_axis_tvalid && s_axis_tready) begin
			predict_request(cur_req);
			n_reqs++;
		end
		if (!s_axis_tvalid || s_axis_tready) begin
			if (arst_n && pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				nxt = pending_reqs.pop_front();
				cur_req = nxt;
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= nxt.cmd;
				s_axis_tdata <= {7'd0, nxt.tag, nxt.angle, nxt.pick, nxt.dy, nxt.dx};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : check_results
		wheel_cmd_t got, exp_cmd;
		if (m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.left_v = m_axis_tdata[15:0];
			got.right_v = m_axis_tdata[31:16];
			got.pick = m_axis_tdata[32];
			got.angle = m_axis_tdata[40:33];
			got.tag = m_axis_tdata[48:41];
			got.trunc = m_axis_tdata[49];
			got.last = m_axis_tlast;
			n_results++;
			if (expected_cmds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %p", $time, got);
			end else begin
				exp_cmd = expected_cmds.pop_front();
				if (got != exp_cmd) begin
					errors++;
					$display("%0t: mismatch, expected %p, actual %p", $time, exp_cmd, got);
				end
			end
		end
		if (arst_n)
			m_axis_tready <= $urandom_range(99) >= stall_pct;
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			ddmp_pkg::REG_HALF_TRACK: half_track = val[15:0];
			ddmp_pkg::REG_RATE:       rate_hz = val[9:0];
			ddmp_pkg::REG_MAX_SPEED:  speed_lim = val[15:0];
			ddmp_pkg::REG_DEG_SCALE:  deg_scale = val[23:0];
			default: ;
		endcase
	endtask

	task automatic set_planner(input logic [31:0] ht, input logic [31:0] rt,
			input logic [31:0] sp, input logic [31:0] sc);
		write_reg(ddmp_pkg::REG_HALF_TRACK, ht);
		write_reg(ddmp_pkg::REG_RATE, rt);
		write_reg(ddmp_pkg::REG_MAX_SPEED, sp);
		write_reg(ddmp_pkg::REG_DEG_SCALE, sc);
	endtask

	// hold until the block has gone quiet
	task automatic drain;
		while (pending_reqs.size() != 0 || s_axis_tvalid || expected_cmds.size() != 0)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic add_req(input ddmp_pkg::cmd_t c, input int dx, input int dy, input int pick,
			input int angle, input int tag);
		request_t r;
		r.cmd = c;
		r.dx = 16'(dx);
		r.dy = 16'(dy);
		r.pick = pick[0];
		r.angle = 8'(angle);
		r.tag = 8'(tag);
		pending_reqs.push_back(r);
	endtask

	task automatic add_random_req;
		int sel, lim;
		sel = $urandom_range(99);
		if (sel < 80) begin
			lim = $urandom_range(99) < 70 ? 300 : 32768;
			add_req(ddmp_pkg::CMD_MOVE, $urandom_range(2 * lim - 1) - lim,
				$urandom_range(2 * lim - 1) - lim, $urandom_range(1), $urandom_range(255),
				$urandom_range(255));
		end else if (sel < 90) begin
			add_req(ddmp_pkg::CMD_SERVO, $urandom, $urandom, $urandom_range(1),
				$urandom_range(255), $urandom_range(255));
		end else if (sel < 96) begin
			add_req(ddmp_pkg::CMD_HOME, $urandom, $urandom, $urandom_range(1),
				$urandom_range(255), $urandom_range(255));
		end else begin
			add_req(ddmp_pkg::CMD_NONE, $urandom, $urandom, $urandom_range(1),
				$urandom_range(255), $urandom_range(255));
		end
	endtask

	initial begin : timeout
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		int idle_mode[4][2];
		logic [31:0] settings[4][4];
		idle_mode = '{'{0, 0}, '{67, 0}, '{0, 67}, '{36, 36}};
		settings = '{'{12800, 10, 100, 187745},
			'{65535, 1000, 65535, 24'hFFFFFF},
			'{0, 1, 1, 1},
			'{3000, 50, 400, 200000}};
		errors = 0;
		n_reqs = 0;
		n_results = 0;
		n_truncated = 0;
		idle_pct = 0;
		stall_pct = 0;
		heading = '0;
		half_track = 12800;
		rate_hz = 10;
		speed_lim = 100;
		deg_scale = 187745;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = ddmp_pkg::CMD_MOVE;
		m_axis_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes of the fields, every command
		add_req(ddmp_pkg::CMD_MOVE, 0, 0, 0, 0, 1);
		add_req(ddmp_pkg::CMD_MOVE, 100, 0, 0, 0, 2);
		add_req(ddmp_pkg::CMD_MOVE, -100, 0, 0, 0, 3);
		add_req(ddmp_pkg::CMD_MOVE, 100, 0, 0, 0, 4);
		add_req(ddmp_pkg::CMD_MOVE, 1000, 5, 0, 0, 5);
		add_req(ddmp_pkg::CMD_MOVE, 32767, 32767, 1, 255, 6);
		add_req(ddmp_pkg::CMD_MOVE, -32768, -32768, 0, 0, 7);
		add_req(ddmp_pkg::CMD_MOVE, -32768, 0, 0, 0, 8);
		add_req(ddmp_pkg::CMD_MOVE, 0, -1, 0, 0, 9);
		add_req(ddmp_pkg::CMD_MOVE, 1, 0, 0, 0, 10);
		add_req(ddmp_pkg::CMD_SERVO, -1, -1, 1, 255, 255);
		add_req(ddmp_pkg::CMD_SERVO, 0, 0, 0, 0, 0);
		add_req(ddmp_pkg::CMD_HOME, 0, 0, 0, 0, 11);
		add_req(ddmp_pkg::CMD_MOVE, 0, 50, 0, 0, 12);
		add_req(ddmp_pkg::CMD_NONE, 77, -77, 1, 9, 13);
		add_req(ddmp_pkg::CMD_MOVE, 0, 50, 0, 0, 14);
		drain();
		set_planner(65535, 1000, 0, 24'hFFFFFF);
		add_req(ddmp_pkg::CMD_MOVE, 32767, -32768, 0, 0, 15);
		add_req(ddmp_pkg::CMD_MOVE, -5, 3, 0, 0, 16);
		add_req(ddmp_pkg::CMD_SERVO, 0, 0, 1, 128, 17);
		drain();
		set_planner(12800, 0, 100, 187745);
		add_req(ddmp_pkg::CMD_MOVE, 30, 40, 0, 0, 18);
		add_req(ddmp_pkg::CMD_MOVE, -30, -40, 0, 0, 19);
		drain();

		for (int s = 0; s < 4; s++) begin
			set_planner(settings[s][0], settings[s][1], settings[s][2], settings[s][3]);
			for (int m = 0; m < 4; m++) begin
				idle_pct = idle_mode[m][0];
				stall_pct = idle_mode[m][1];
				repeat (27) add_random_req();
				drain();
			end
		end
		idle_pct = 0;
		stall_pct = 0;

		if (expected_cmds.size() != 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, expected_cmds.size());
		end
		$display("Covered %0d requests and %0d results (%0d truncated segments)",
			n_reqs, n_results, n_truncated);
		$display("across four register settings and four idle/stall mixes");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
